[design/stxd_pkg.sv]
// Package for the STX / length / checksum deframer.
// Holds the frame constants, the phase and event codes and the stage types.
// No dependencies.
package stxd_pkg;

  localparam int unsigned TimeoutBitsDef = 16;
  localparam int unsigned CfgWidth       = 16;

  localparam logic [CfgWidth-1:0] IdleTimeoutRst = 16'd250;

  localparam logic [7:0] StartByte = 8'h02;
  localparam logic [7:0] ReplyType = 8'h90;
  localparam logic [2:0] HeaderLen = 3'd6;
  localparam logic [2:0] TypePos   = 3'd2;
  localparam logic [2:0] LengthPos = 3'd5;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HEADER,
    PH_PAYLOAD,
    PH_CHECK
  } phase_e;

  typedef enum logic [2:0] {
    EV_PAYLOAD = 3'd0,
    EV_OK      = 3'd1,
    EV_BAD     = 3'd2,
    EV_TIMEOUT = 3'd3,
    EV_DISCARD = 3'd4
  } event_e;

  // One request held in the input register.
  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [7:0] rx_byte;
  } in_stage_t;

  // One result as held in the result register.
  typedef struct packed {
    event_e     event_res;
    logic [7:0] value;
    logic [7:0] payload_index;
    logic [7:0] frame_type;
    logic [7:0] frame_length;
    logic       is_reply;
  } result_t;

endpackage

[design/stxd_if.sv]
// Stream interfaces of the deframer: input requests and result items.
// Both use a valid / ready handshake. No dependencies.
interface stxd_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;

  modport source (output valid, kind, rx_byte, input ready);
  modport sink   (input valid, kind, rx_byte, output ready);
endinterface

interface stxd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [7:0] value;
  logic [7:0] payload_index;
  logic [7:0] frame_type;
  logic [7:0] frame_length;
  logic       is_reply;

  modport source (output valid, event_res, value, payload_index, frame_type, frame_length,
                  is_reply, input ready);
  modport sink   (input valid, event_res, value, payload_index, frame_type, frame_length,
                  is_reply, output ready);
endinterface

[design/stx_length_checksum_deframer.sv]
// Deframer for STX / length / checksum frames carried over a UART byte stream.
// Takes one request per clock while results are taken (a received byte or one time tick)
// and gives at most one result per request: the request waits in the input register,
// and its result is captured in the result register as the request leaves it. A stalled
// result holds new requests. The rate is set by the single
// frame state machine that updates once per request. Bytes outside a frame are reported as
// discarded; payload bytes come out with their index; the checksum byte ends the frame with
// a good or bad verdict. idle_timeout ticks without a byte inside a frame abort it.
// Depends on stxd_pkg, stxd_if, stxd_in_stage and stxd_core.
module stx_length_checksum_deframer #(
  parameter int unsigned TimeoutBits = stxd_pkg::TimeoutBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [stxd_pkg::CfgWidth-1:0] cfg_wdata_i,
  stxd_in_if.sink                       in_i,
  stxd_out_if.source                    res_o
);

  logic [stxd_pkg::CfgWidth-1:0] idle_timeout_q;
  stxd_pkg::in_stage_t           stage;
  stxd_pkg::result_t             res;
  logic                          advance;
  logic                          res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_timeout_q <= stxd_pkg::IdleTimeoutRst;
    end else if (cfg_we_i) begin
      idle_timeout_q <= cfg_wdata_i;
    end
  end

  stxd_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .stage_o   (stage)
  );

  stxd_core #(
    .TimeoutBits (TimeoutBits)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .stage_i        (stage),
    .idle_timeout_i (idle_timeout_q),
    .res_ready_i    (res_o.ready),
    .advance_o      (advance),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  assign res_o.valid         = res_valid;
  assign res_o.event_res     = res.event_res;
  assign res_o.value         = res.value;
  assign res_o.payload_index = res.payload_index;
  assign res_o.frame_type    = res.frame_type;
  assign res_o.frame_length  = res.frame_length;
  assign res_o.is_reply      = res.is_reply;

`ifndef SYNTH
  // Discarded bytes carry no frame context.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res.event_res == stxd_pkg::EV_DISCARD |->
      res.frame_type == 8'd0 && res.frame_length == 8'd0 && !res.is_reply)
    else $error("discard result carries frame fields");

  // The reply flag follows the reported type inside a frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res.event_res != stxd_pkg::EV_DISCARD |->
      res.is_reply == (res.frame_type == stxd_pkg::ReplyType))
    else $error("reply flag disagrees with frame type");

  // A payload byte always lies inside the announced length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res.event_res == stxd_pkg::EV_PAYLOAD |->
      res.payload_index < res.frame_length)
    else $error("payload index beyond frame length");

  // A stalled result with a full input register blocks new requests.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage.valid && res_valid && !res_o.ready |-> !in_i.ready)
    else $error("request accepted while pipeline is full");
`endif

endmodule

[design/stxd_in_stage.sv]
// Input register of the deframer: captures one request per cycle when free.
// Depends on stxd_pkg and stxd_in_if.
module stxd_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  stxd_in_if.sink             in_i,
  input  logic                advance_i,
  output stxd_pkg::in_stage_t stage_o
);

  logic       valid_q;
  logic       kind_q;
  logic [7:0] rx_byte_q;
  logic       load;

  // Take a new request when the register is empty or drains this cycle.
  assign in_i.ready = !valid_q || advance_i;
  assign load       = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q    <= in_i.kind;
      rx_byte_q <= in_i.rx_byte;
    end
  end

  assign stage_o = '{valid: valid_q, kind: kind_q, rx_byte: rx_byte_q};

endmodule

[design/stxd_core.sv]
// Frame state machine and result register of the deframer.
// Depends on stxd_pkg.
module stxd_core #(
  parameter int unsigned TimeoutBits = stxd_pkg::TimeoutBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  stxd_pkg::in_stage_t                stage_i,
  input  logic [stxd_pkg::CfgWidth-1:0]      idle_timeout_i,
  input  logic                               res_ready_i,
  output logic                               advance_o,
  output logic                               res_valid_o,
  output stxd_pkg::result_t                  res_o
);

  localparam int unsigned CmpW =
      (TimeoutBits > stxd_pkg::CfgWidth) ? TimeoutBits : stxd_pkg::CfgWidth;

  stxd_pkg::phase_e     phase_q, phase_d;
  logic [2:0]           hdr_cnt_q, hdr_cnt_d;
  logic [7:0]           type_q, type_d;
  logic [7:0]           len_q, len_d;
  logic [7:0]           pos_q, pos_d;
  logic [7:0]           sum_q, sum_d;
  logic [TimeoutBits-1:0] ticks_q, ticks_d, ticks_inc;
  logic                 timeout_hit;
  logic [7:0]           sum_add;
  logic [7:0]           pos_inc;
  logic                 fire;
  logic                 emit;
  stxd_pkg::result_t    res_d, res_q;
  logic                 res_valid_q;

  // The result register frees up when empty or when its result is taken.
  assign advance_o = !res_valid_q || res_ready_i;
  assign fire      = advance_o && stage_i.valid;

  // Saturating idle counter, compared at the common width.
  assign ticks_inc   = (ticks_q == '1) ? ticks_q : ticks_q + 1'b1;
  assign timeout_hit = CmpW'(ticks_inc) >= CmpW'(idle_timeout_i);
  assign sum_add     = sum_q + stage_i.rx_byte;
  assign pos_inc     = pos_q + 8'd1;

  // Next state.
  always_comb begin
    phase_d   = phase_q;
    hdr_cnt_d = hdr_cnt_q;
    type_d    = type_q;
    len_d     = len_q;
    pos_d     = pos_q;
    sum_d     = sum_q;
    ticks_d   = ticks_q;
    if (stage_i.kind) begin
      if (phase_q != stxd_pkg::PH_HUNT) begin
        if (timeout_hit) begin
          phase_d = stxd_pkg::PH_HUNT;
          ticks_d = '0;
        end else begin
          ticks_d = ticks_inc;
        end
      end
    end else begin
      case (phase_q)
        stxd_pkg::PH_HUNT: begin
          if (stage_i.rx_byte == stxd_pkg::StartByte) begin
            phase_d   = stxd_pkg::PH_HEADER;
            hdr_cnt_d = '0;
            type_d    = '0;
            len_d     = '0;
            pos_d     = '0;
            sum_d     = '0;
            ticks_d   = '0;
          end
        end
        stxd_pkg::PH_HEADER: begin
          ticks_d = '0;
          sum_d   = sum_add;
          if (hdr_cnt_q == stxd_pkg::TypePos) begin
            type_d = stage_i.rx_byte;
          end
          if (hdr_cnt_q == stxd_pkg::LengthPos) begin
            len_d   = stage_i.rx_byte;
            pos_d   = '0;
            phase_d = (stage_i.rx_byte == 8'd0) ? stxd_pkg::PH_CHECK : stxd_pkg::PH_PAYLOAD;
          end
          hdr_cnt_d = (hdr_cnt_q >= stxd_pkg::HeaderLen) ? stxd_pkg::HeaderLen
                                                         : hdr_cnt_q + 3'd1;
        end
        stxd_pkg::PH_PAYLOAD: begin
          ticks_d = '0;
          sum_d   = sum_add;
          pos_d   = pos_inc;
          if (pos_inc == len_q) begin
            phase_d = stxd_pkg::PH_CHECK;
          end
        end
        stxd_pkg::PH_CHECK: begin
          ticks_d = '0;
          phase_d = stxd_pkg::PH_HUNT;
        end
        default: begin
          phase_d = stxd_pkg::PH_HUNT;
        end
      endcase
    end
  end

  // Result of the current request.
  always_comb begin
    emit                = 1'b0;
    res_d.event_res     = stxd_pkg::EV_PAYLOAD;
    res_d.value         = stage_i.rx_byte;
    res_d.payload_index = '0;
    res_d.frame_type    = type_q;
    res_d.frame_length  = len_q;
    res_d.is_reply      = (type_q == stxd_pkg::ReplyType);
    if (stage_i.kind) begin
      if (phase_q != stxd_pkg::PH_HUNT && timeout_hit) begin
        emit            = 1'b1;
        res_d.event_res = stxd_pkg::EV_TIMEOUT;
        res_d.value     = '0;
      end
    end else begin
      case (phase_q)
        stxd_pkg::PH_HUNT: begin
          emit               = (stage_i.rx_byte != stxd_pkg::StartByte);
          res_d.event_res    = stxd_pkg::EV_DISCARD;
          res_d.frame_type   = '0;
          res_d.frame_length = '0;
          res_d.is_reply     = 1'b0;
        end
        stxd_pkg::PH_HEADER: begin
          emit = 1'b0;
        end
        stxd_pkg::PH_PAYLOAD: begin
          emit                = 1'b1;
          res_d.event_res     = stxd_pkg::EV_PAYLOAD;
          res_d.payload_index = pos_q;
        end
        stxd_pkg::PH_CHECK: begin
          emit            = 1'b1;
          res_d.event_res = ((8'd0 - sum_q) == stage_i.rx_byte) ? stxd_pkg::EV_OK
                                                                : stxd_pkg::EV_BAD;
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= stxd_pkg::PH_HUNT;
      hdr_cnt_q <= '0;
      type_q    <= '0;
      len_q     <= '0;
      pos_q     <= '0;
      sum_q     <= '0;
      ticks_q   <= '0;
    end else if (fire) begin
      phase_q   <= phase_d;
      hdr_cnt_q <= hdr_cnt_d;
      type_q    <= type_d;
      len_q     <= len_d;
      pos_q     <= pos_d;
      sum_q     <= sum_d;
      ticks_q   <= ticks_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance_o) begin
      res_valid_q <= fire && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

[bench/stxd_checker.sv]
// Checker for the STX / length / checksum deframer: watches the request, result and
// register ports, predicts every result and compares it with what the block delivers.
// Depends on stxd_pkg and stxd_if.
module stxd_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [stxd_pkg::CfgWidth-1:0] cfg_wdata_i,
  stxd_in_if                            in_mon,
  stxd_out_if                           res_mon,
  output int                            mismatches_o,
  output int                            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import stxd_pkg::*;

  localparam int unsigned IdleBits    = TimeoutBitsDef;
  localparam int          ReportLimit = 10;

  logic [CfgWidth-1:0] timeout_reg;
  phase_e              ph;
  logic [2:0]          hdr_cnt;
  logic [7:0]          type_q;
  logic [7:0]          len_q;
  logic [7:0]          pos_q;
  logic [7:0]          sum_q;
  logic [IdleBits-1:0] idle_q;
  result_t             expected_q[$];
  int                  mismatches;

  function automatic result_t frame_result(input event_e ev, input logic [7:0] val,
                                           input logic [7:0] idx);
    result_t r;
    r.event_res     = ev;
    r.value         = val;
    r.payload_index = idx;
    r.frame_type    = type_q;
    r.frame_length  = len_q;
    r.is_reply      = (type_q == ReplyType);
    return r;
  endfunction

  // Advance the frame state by one request; returns 1 when the request gives a result.
  function automatic bit deframe(input logic kind, input logic [7:0] b, output result_t r);
    logic [7:0] calc;
    r = '0;
    if (kind) begin
      if (ph == PH_HUNT) return 1'b0;
      if (idle_q != '1) idle_q = idle_q + 1'b1;
      if (idle_q >= timeout_reg) begin
        r      = frame_result(EV_TIMEOUT, 8'h00, 8'h00);
        ph     = PH_HUNT;
        idle_q = '0;
        return 1'b1;
      end
      return 1'b0;
    end
    if (ph == PH_HUNT) begin
      if (b == StartByte) begin
        ph      = PH_HEADER;
        hdr_cnt = '0;
        type_q  = '0;
        len_q   = '0;
        pos_q   = '0;
        sum_q   = '0;
        idle_q  = '0;
        return 1'b0;
      end
      r.event_res = EV_DISCARD;
      r.value     = b;
      return 1'b1;
    end
    idle_q = '0;
    case (ph)
      PH_HEADER: begin
        sum_q = sum_q + b;
        if (hdr_cnt == TypePos) type_q = b;
        if (hdr_cnt == LengthPos) begin
          len_q = b;
          pos_q = '0;
          ph    = (b == 8'h00) ? PH_CHECK : PH_PAYLOAD;
        end
        hdr_cnt = (hdr_cnt >= HeaderLen) ? HeaderLen : hdr_cnt + 3'd1;
        return 1'b0;
      end
      PH_PAYLOAD: begin
        sum_q = sum_q + b;
        r     = frame_result(EV_PAYLOAD, b, pos_q);
        pos_q = pos_q + 8'd1;
        if (pos_q == len_q) ph = PH_CHECK;
        return 1'b1;
      end
      default: begin
        calc = 8'h00 - sum_q;
        r    = frame_result((calc == b) ? EV_OK : EV_BAD, b, 8'h00);
        ph   = PH_HUNT;
        return 1'b1;
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t exp_r;
    bit      differs;
    if (!rst_ni) begin
      timeout_reg = IdleTimeoutRst;
      ph          = PH_HUNT;
      hdr_cnt     = '0;
      type_q      = '0;
      len_q       = '0;
      pos_q       = '0;
      sum_q       = '0;
      idle_q      = '0;
      mismatches  = 0;
      expected_q.delete();
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportLimit)
            $display("%0t: unexpected result ev=%0d val=%02h idx=%0d type=%02h len=%0d rep=%0b",
                     $realtime, res_mon.event_res, res_mon.value, res_mon.payload_index,
                     res_mon.frame_type, res_mon.frame_length, res_mon.is_reply);
        end else begin
          exp_r   = expected_q.pop_front();
          differs = (res_mon.event_res !== exp_r.event_res) ||
                    (res_mon.value !== exp_r.value) ||
                    (res_mon.payload_index !== exp_r.payload_index) ||
                    (res_mon.frame_type !== exp_r.frame_type) ||
                    (res_mon.frame_length !== exp_r.frame_length) ||
                    (res_mon.is_reply !== exp_r.is_reply);
          if (differs) begin
            mismatches++;
            if (mismatches <= ReportLimit)
              $display({"%0t: result mismatch: expected ev=%0d val=%02h idx=%0d type=%02h ",
                        "len=%0d rep=%0b, got ev=%0d val=%02h idx=%0d type=%02h len=%0d rep=%0b"},
                       $realtime, exp_r.event_res, exp_r.value, exp_r.payload_index,
                       exp_r.frame_type, exp_r.frame_length, exp_r.is_reply,
                       res_mon.event_res, res_mon.value, res_mon.payload_index,
                       res_mon.frame_type, res_mon.frame_length, res_mon.is_reply);
          end
        end
      end
      if (cfg_we_i) timeout_reg = cfg_wdata_i;
      if (in_mon.valid && in_mon.ready) begin
        if (deframe(in_mon.kind, in_mon.rx_byte, exp_r)) expected_q.push_back(exp_r);
      end
    end
    mismatches_o = mismatches;
    pending_o    = expected_q.size();
  end

endmodule

[bench/tb_top.sv]
// Top of the deframer testbench: clock, reset, request and register stimulus, result
// stalls and the verdict. Prediction and comparison live in stxd_checker.
// Depends on stxd_pkg, stxd_if, stxd_checker and stx_length_checksum_deframer.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import stxd_pkg::*;

  localparam int  LongHoldCycles = 300;
  localparam int  SettleCycles   = 6;
  localparam longint CycleLimit  = 400000;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgWidth-1:0] cfg_wdata_i;

  int     send_idle_pct  = 0;
  int     recv_stall_pct = 0;
  int     cur_timeout    = 250;
  int     bytes_sent     = 0;
  int     hold_req_seq   = 0;
  int     mismatch_count;
  int     pending_count;
  longint cycle_count    = 0;

  stxd_in_if  in_if ();
  stxd_out_if res_if ();

  stx_length_checksum_deframer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .res_o       (res_if)
  );

  stxd_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_mon       (in_if),
    .res_mon      (res_if),
    .mismatches_o (mismatch_count),
    .pending_o    (pending_count)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left    = 0;
    hold_seen    = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_seen != hold_req_seq) begin
        hold_seen = hold_req_seq;
        hold_left = LongHoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic push_request(input logic kind, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.kind    <= kind;
    in_if.rx_byte <= b;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
    if (!kind) bytes_sent++;
  endtask

  task automatic send_tick();
    push_request(1'b1, 8'($urandom));
  endtask

  // Insert a few ticks that stay below the abort threshold.
  task automatic maybe_idle_ticks();
    int n;
    if (cur_timeout > 1 && $urandom_range(99) < 20) begin
      n = $urandom_range(1, (cur_timeout - 1 < 4) ? cur_timeout - 1 : 4);
      repeat (n) send_tick();
    end
  endtask

  // Send one frame; with cut_at >= 0 stop before that byte and tick it into an abort.
  task automatic send_frame(input logic [7:0] ftype, input logic [7:0] flen,
                            input bit good_sum, input int cut_at);
    logic [7:0] frame_bytes[$];
    logic [7:0] sum;
    int         i;
    sum         = '0;
    frame_bytes = {StartByte};
    for (i = 0; i < 6; i++)
      frame_bytes.push_back((i == TypePos) ? ftype : (i == LengthPos) ? flen : 8'($urandom));
    for (i = 0; i < flen; i++) frame_bytes.push_back(8'($urandom));
    for (i = 1; i < frame_bytes.size(); i++) sum = sum + frame_bytes[i];
    frame_bytes.push_back(good_sum ? 8'h00 - sum
                                   : (8'h00 - sum) ^ 8'($urandom_range(1, 255)));
    for (i = 0; i < frame_bytes.size(); i++) begin
      if (i == cut_at) begin
        repeat (cur_timeout) send_tick();
        return;
      end
      if (i > 0) maybe_idle_ticks();
      push_request(1'b0, frame_bytes[i]);
    end
  endtask

  function automatic logic [7:0] pick_type();
    return ($urandom_range(3) == 0) ? ReplyType : 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_len();
    return ($urandom_range(99) < 85) ? 8'($urandom_range(0, 6)) : 8'($urandom_range(7, 20));
  endfunction

  // Drop valid, wait for every expected result, then let the pipeline drain.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_timeout(input int v);
    cfg_wdata_i <= CfgWidth'(v);
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_timeout = v;
  endtask

  task automatic start_phase(input int timeout, input int send_pct, input int recv_pct);
    settle();
    write_timeout(timeout);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic random_traffic(input int n);
    int stop;
    int roll;
    logic [7:0] len;
    stop = bytes_sent + n;
    while (bytes_sent < stop) begin
      roll = $urandom_range(99);
      len  = pick_len();
      if (roll < 80) begin
        send_frame(pick_type(), len, $urandom_range(99) < 85, -1);
      end else if (roll < 90) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(99) < 70) push_request(1'b0, 8'($urandom));
          else send_tick();
        end
      end else if (cur_timeout <= 8) begin
        send_frame(pick_type(), len, 1'b1, $urandom_range(1, 7 + len));
      end else begin
        send_frame(pick_type(), len, 1'b0, -1);
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_if.valid   = 1'b0;
    in_if.kind    = 1'b0;
    in_if.rx_byte = '0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Directed: discards while hunting, reply frame, empty frame with a bad checksum,
    // a tick inside a frame, then an abort before any type or length byte.
    push_request(1'b0, 8'h00);
    push_request(1'b0, 8'hFF);
    send_tick();
    push_request(1'b0, 8'h7F);
    send_frame(ReplyType, 8'd2, 1'b1, -1);
    send_frame(8'h00, 8'd0, 1'b0, -1);
    push_request(1'b0, StartByte);
    send_tick();
    push_request(1'b0, 8'h01);
    start_phase(1, 0, 0);
    send_tick();

    start_phase(3, 0, 0);
    hold_req_seq++;
    random_traffic(50);

    start_phase(65535, 77, 0);
    random_traffic(10);
    send_frame(pick_type(), 8'd255, 1'b1, -1);
    random_traffic(10);

    start_phase(1, 0, 77);
    random_traffic(50);

    start_phase(7, 11, 11);
    random_traffic(50);

    settle();
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[files.f]
design/stxd_pkg.sv
design/stxd_if.sv
design/stxd_in_stage.sv
design/stxd_core.sv
design/stx_length_checksum_deframer.sv
bench/stxd_checker.sv
bench/tb_top.sv
